@@ src/dmul_pkg.sv @@
// Shared types, constants and digit helpers for the decimal digit multiplier.
// No dependencies; every other file of the block imports this package.
package dmul_pkg;

   // Default operand length in digits
   localparam int MAX_DIGITS_DEF = 32;
   localparam int RADIX          = 10;
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   typedef logic [3:0] digit_type;

   // One accepted input word, as seen by the operand store
   typedef struct packed {
      logic      load;
      logic      kind;
      digit_type digit;
      logic      last;
   } load_word_type;

   // Operand store status toward the product sequencer
   typedef struct packed {
      logic start;
      logic overflow;
   } opnd_flags_type;

   // Quotient and remainder of a small value by ten
   typedef struct packed {
      digit_type quo;
      digit_type rem;
   } divmod_type;

   // Saturate a raw nibble to a decimal digit
   function automatic digit_type clamp_digit(input logic [3:0] d);
      return (d > DIGIT_MAX) ? DIGIT_MAX : d;
   endfunction

   // Split a value below 100 into tens and units by threshold compares
   function automatic divmod_type split_decimal(input logic [7:0] v);
      divmod_type res;
      logic [7:0] tens;
      res.quo = '0;
      for (int k = 1; k < RADIX; k++) begin
         if (v >= 8'(RADIX * k)) begin
            res.quo = 4'(k);
         end
      end
      tens    = 8'(res.quo) * 8'(RADIX);
      res.rem = 4'(v - tens);
      return res;
   endfunction

endpackage

@@ src/dmul_operands.sv @@
// Operand store: digit memories for both operands, digit counts and overflow flag.
// Depends on dmul_pkg.
module dmul_operands import dmul_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF,
   localparam int CW = $clog2(MAX_DIGITS + 1),
   localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  load_word_type  word,
   input  logic           clear,
   input  logic [AW-1:0]  a_addr,
   input  logic [AW-1:0]  b_addr,
   output digit_type      a_data,
   output digit_type      b_data,
   output logic [CW-1:0]  first_count,
   output logic [CW-1:0]  second_count,
   output opnd_flags_type flags
);

   digit_type first_mem  [MAX_DIGITS];
   digit_type second_mem [MAX_DIGITS];

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic          overflow_ff, overflow_in;
   logic          start_ff, start_in;
   digit_type     a_rd_ff, b_rd_ff;
   logic          first_room, second_room;
   logic          first_we, second_we;

   assign first_room  = first_count_ff < CW'(MAX_DIGITS);
   assign second_room = second_count_ff < CW'(MAX_DIGITS);
   assign first_we    = word.load & ~word.kind & first_room;
   assign second_we   = word.load & word.kind & second_room;

   // Advance counts, flag dropped digits, drop everything on clear
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      start_in        = word.load & word.kind & word.last;
      if (clear) begin
         first_count_in  = '0;
         second_count_in = '0;
         overflow_in     = 1'b0;
      end else if (word.load) begin
         if (!word.kind) begin
            if (first_room) begin
               first_count_in = first_count_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end else begin
            if (second_room) begin
               second_count_in = second_count_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         start_ff        <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         start_ff        <= start_in;
      end
   end

   // Digit memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[first_count_ff[AW-1:0]] <= word.digit;
      end
      if (second_we) begin
         second_mem[second_count_ff[AW-1:0]] <= word.digit;
      end
      a_rd_ff <= first_mem[a_addr];
      b_rd_ff <= second_mem[b_addr];
   end

   assign a_data         = a_rd_ff;
   assign b_data         = b_rd_ff;
   assign first_count    = first_count_ff;
   assign second_count   = second_count_ff;
   assign flags.start    = start_ff;
   assign flags.overflow = overflow_ff;

endmodule

@@ src/dmul_product.sv @@
// Product sequencer: digit-by-digit schoolbook multiply into a column memory,
// then most-significant-first readout with leading zeros stripped. Uses dmul_pkg.
module dmul_product import dmul_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF,
   localparam int CW  = $clog2(MAX_DIGITS + 1),
   localparam int AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
   localparam int CAW = $clog2(2 * MAX_DIGITS)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [CW-1:0]  first_count,
   input  logic [CW-1:0]  second_count,
   input  opnd_flags_type flags,
   input  digit_type      a_data,
   input  digit_type      b_data,
   output logic [AW-1:0]  a_addr,
   output logic [AW-1:0]  b_addr,
   output logic           clear,
   output logic           idle,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output digit_type      rsp_digit_res,
   output logic           rsp_last_res,
   output logic           rsp_overflow
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_SCAN,
      ST_CHECK,
      ST_ZERO
   } state_type;

   state_type state_ff, state_in;

   digit_type col_mem [2 * MAX_DIGITS];
   digit_type col_rd_ff;

   logic [CW-1:0]  n_ff, n_in, m_ff, m_in, i_ff, i_in, j_ff, j_in;
   logic           ovf_ff, ovf_in;
   digit_type      carry_ff, carry_in;
   logic           s1_valid_ff, s1_valid_in;
   logic           s1_flush_ff, s1_flush_in;
   logic           s1_first_ff, s1_first_in;
   logic [CAW-1:0] s1_col_ff, s1_col_in;
   logic           byp_hit_ff, byp_hit_in;
   digit_type      byp_data_ff, byp_data_in;
   logic [CAW-1:0] k_ff, k_in;
   logic           lead_ff, lead_in;
   logic           rsp_valid_ff, rsp_valid_in;
   digit_type      rsp_digit_ff, rsp_digit_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic [CW-1:0]  a_idx, b_idx;
   logic [CW:0]    col_sum, total_m1;
   logic [CAW-1:0] col_raddr;
   logic           col_we;
   digit_type      col_wdata;
   digit_type      c_val;
   logic [7:0]     pp_sum;
   divmod_type     dm;
   logic           out_free;

   // Operand read addresses, least significant digit first
   assign a_idx    = n_ff - i_ff - 1'b1;
   assign b_idx    = m_ff - j_ff - 1'b1;
   assign a_addr   = a_idx[AW-1:0];
   assign b_addr   = b_idx[AW-1:0];
   assign col_sum  = {1'b0, i_ff} + {1'b0, j_ff};
   assign total_m1 = {1'b0, n_ff} + {1'b0, m_ff} - 1'b1;
   assign col_raddr = (state_ff == ST_MUL) ? col_sum[CAW-1:0] : k_ff;

   // Digit cell: one digit product plus column plus carry per cycle
   assign c_val  = s1_first_ff ? '0 : (byp_hit_ff ? byp_data_ff : col_rd_ff);
   assign pp_sum = 8'(a_data) * 8'(b_data) + 8'(c_val) + 8'(carry_ff);
   assign dm     = split_decimal(pp_sum);

   assign col_we    = s1_valid_ff;
   assign col_wdata = s1_flush_ff ? carry_ff : dm.rem;

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign clear    = (state_ff == ST_IDLE) & flags.start;
   assign idle     = (state_ff == ST_IDLE) & ~flags.start;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      lead_in      = lead_ff;
      carry_in     = carry_ff;
      s1_valid_in  = 1'b0;
      s1_flush_in  = j_ff == m_ff;
      s1_first_in  = i_ff == '0;
      s1_col_in    = col_sum[CAW-1:0];
      byp_hit_in   = col_we & (s1_col_ff == col_raddr);
      byp_data_in  = col_wdata;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // Carry follows the digit cell; a flush step hands it to the top column
      if (s1_valid_ff) begin
         carry_in = s1_flush_ff ? '0 : dm.quo;
      end

      case (state_ff)
         ST_IDLE: begin
            if (flags.start) begin
               n_in     = first_count;
               m_in     = second_count;
               ovf_in   = flags.overflow;
               i_in     = '0;
               j_in     = '0;
               carry_in = '0;
               if (first_count == '0 || second_count == '0) begin
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // Issue one step: a digit pair, or the row's carry flush
            s1_valid_in = 1'b1;
            if (j_ff == m_ff) begin
               j_in = '0;
               if (i_ff == n_ff - 1'b1) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            k_in     = total_m1[CAW-1:0];
            lead_in  = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // Skip leading zeros, but always keep the lowest column
            if (lead_ff && col_rd_ff == '0 && k_ff != '0) begin
               k_in     = k_ff - 1'b1;
               state_in = ST_SCAN;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = col_rd_ff;
               rsp_last_in  = k_ff == '0;
               rsp_ovf_in   = ovf_ff;
               lead_in      = 1'b0;
               if (k_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff - 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = '0;
               rsp_last_in  = 1'b1;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         byp_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         byp_hit_ff   <= byp_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      m_ff         <= m_in;
      ovf_ff       <= ovf_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      lead_ff      <= lead_in;
      carry_ff     <= carry_in;
      s1_flush_ff  <= s1_flush_in;
      s1_first_ff  <= s1_first_in;
      s1_col_ff    <= s1_col_in;
      byp_data_ff  <= byp_data_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // Column memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[s1_col_ff] <= col_wdata;
      end
      col_rd_ff <= col_mem[col_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_digit_res = rsp_digit_ff;
   assign rsp_last_res  = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

@@ src/decimal_digit_multiplier_core.sv @@
// Top level of the decimal digit multiplier: operand store plus product sequencer.
// Depends on dmul_pkg, dmul_operands and dmul_product.

// Digits load one word per cycle between products, first operand then second, most
// significant first; a digit above nine counts as nine, and digits beyond MAX_DIGITS per
// operand are dropped and reported through rsp_overflow on every digit of that product. The
// second-operand word with req_last set closes the pair: req_ready then drops for the whole
// product. With n and m digits kept, the multiply runs n rows of m digit products and a
// carry flush, one step per cycle through the column memory's read-modify-write, between
// start and drain steps. Readout then has a scan and a check state per product digit and
// per stripped leading zero, set by the registered read of the column memory; an empty
// operand yields the single digit 0. req_ready returns as soon as the final product digit
// sits in the output register, so the next operands load while it waits to be taken.
module decimal_digit_multiplier_core import dmul_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_kind,
   input  digit_type req_digit,
   input  logic      req_last,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output digit_type rsp_digit_res,
   output logic      rsp_last_res,
   output logic      rsp_overflow
);

   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   load_word_type  word;
   opnd_flags_type flags;
   logic [CW-1:0]  first_count, second_count;
   logic [AW-1:0]  a_addr, b_addr;
   digit_type      a_data, b_data;
   logic           clear, idle;

   // Accept a word only between products
   assign req_ready = idle;

   always_comb begin
      word.load  = req_valid & req_ready;
      word.kind  = req_kind;
      word.digit = clamp_digit(req_digit);
      word.last  = req_last;
   end

   dmul_operands #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_operands (
      .clock        (clock),
      .reset        (reset),
      .word         (word),
      .clear        (clear),
      .a_addr       (a_addr),
      .b_addr       (b_addr),
      .a_data       (a_data),
      .b_data       (b_data),
      .first_count  (first_count),
      .second_count (second_count),
      .flags        (flags)
   );

   dmul_product #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_product (
      .clock         (clock),
      .reset         (reset),
      .first_count   (first_count),
      .second_count  (second_count),
      .flags         (flags),
      .a_data        (a_data),
      .b_data        (b_data),
      .a_addr        (a_addr),
      .b_addr        (b_addr),
      .clear         (clear),
      .idle          (idle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_digit_res (rsp_digit_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

@@ src/dmul_checker.sv @@
// Port-level checks for the decimal digit multiplier, bound to its top level.
// Depends on dmul_pkg and decimal_digit_multiplier_core.
module dmul_checker import dmul_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      req_kind,
   input digit_type req_digit,
   input logic      req_last,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input digit_type rsp_digit_res,
   input logic      rsp_last_res,
   input logic      rsp_overflow
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_res)
         && $stable(rsp_last_res) && $stable(rsp_overflow))
      else $error("result word changed while stalled");

   // Product digits are decimal
   a_rsp_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_res <= DIGIT_MAX)
      else $error("product digit above nine");

   // Closing the second operand stops loading
   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind && req_last |=> !req_ready)
      else $error("input still taken after operands closed");

   // No loading while a product is still being read out
   a_no_load_mid_product: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_res |-> !req_ready)
      else $error("input taken in the middle of a product");

   // Overflow flag is the same on all digits of one product
   a_ovf_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_res |=>
         !rsp_valid || rsp_overflow == $past(rsp_overflow))
      else $error("overflow flag changed within a product");

endmodule

bind decimal_digit_multiplier_core dmul_checker u_dmul_checker (.*);

@@ bench/decimal_digit_multiplier_checker.sv @@
`timescale 1ns / 100ps
// Checker for the decimal digit multiplier: watches both channels, predicts product digits
// and compares each accepted result word. Depends on dmul_pkg for digit types and limits.
module decimal_digit_multiplier_checker import dmul_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_ready,
   input  logic      req_kind,
   input  digit_type req_digit,
   input  logic      req_last,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  digit_type rsp_digit_res,
   input  logic      rsp_last_res,
   input  logic      rsp_overflow,
   output int        mismatch_count,
   output int        open_digits,
   output int        product_count,
   output int        digits_checked
);

   localparam logic KIND_SECOND  = 1'b1;
   localparam int   REPORT_LIMIT = 10;

   typedef struct packed {
      digit_type digit;
      logic      last;
      logic      overflow;
   } product_digit_type;

   product_digit_type product_digit_q[$];

   // Shadow copy of the operand store
   digit_type mcand_digits [MAX_DIGITS];
   digit_type mplier_digits [MAX_DIGITS];
   int        mcand_len;
   int        mplier_len;
   logic      digits_dropped;

   int tally_fail;
   int tally_products;
   int tally_digits;

   // Count a mismatch; print only the first few
   task automatic flag_mismatch(input string msg);
      tally_fail++;
      if (tally_fail <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // Schoolbook multiply of the stored operands; queue the stripped product digits
   function automatic void queue_product();
      int cols [2*MAX_DIGITS];
      int total;
      int sum;
      int col;
      int lead;
      foreach (cols[k]) cols[k] = 0;
      for (int i = mcand_len; i > 0; i--) begin
         for (int j = mplier_len; j > 0; j--) begin
            col          = (i - 1) + (j - 1) + 1;
            sum          = int'(mcand_digits[i-1]) * int'(mplier_digits[j-1]) + cols[col];
            cols[col]    = sum % 10;
            cols[col-1]  = cols[col-1] + sum / 10;
         end
      end
      total = mcand_len + mplier_len;
      lead  = 0;
      while (lead < total && cols[lead] == 0) lead++;
      if (lead >= total) begin
         product_digit_q.push_back('{digit: '0, last: 1'b1, overflow: digits_dropped});
      end else begin
         for (int k = lead; k < total; k++) begin
            product_digit_q.push_back('{digit: 4'(cols[k]), last: (k + 1 == total),
                                        overflow: digits_dropped});
         end
      end
      tally_products++;
      // Clear for the next operand pair
      mcand_len      = 0;
      mplier_len     = 0;
      digits_dropped = 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      product_digit_type want;
      digit_type         d;
      if (reset) begin
         product_digit_q.delete();
         mcand_len      = 0;
         mplier_len     = 0;
         digits_dropped = 1'b0;
         tally_fail     = 0;
         tally_products = 0;
         tally_digits   = 0;
      end else begin
         // Check the result word first: it can only belong to an earlier product
         if (rsp_valid && rsp_ready) begin
            if (product_digit_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected digit %0d last %0b overflow %0b",
                                       rsp_digit_res, rsp_last_res, rsp_overflow));
            end else begin
               want = product_digit_q.pop_front();
               tally_digits++;
               if (rsp_digit_res !== want.digit || rsp_last_res !== want.last ||
                   rsp_overflow !== want.overflow) begin
                  flag_mismatch($sformatf(
                     "expected digit %0d last %0b overflow %0b, got digit %0d last %0b overflow %0b",
                     want.digit, want.last, want.overflow,
                     rsp_digit_res, rsp_last_res, rsp_overflow));
               end
            end
         end
         // Store the input word; the closing second-operand word yields a product
         if (req_valid && req_ready) begin
            d = (req_digit > DIGIT_MAX) ? DIGIT_MAX : req_digit;
            if (req_kind == KIND_SECOND) begin
               if (mplier_len < MAX_DIGITS) begin
                  mplier_digits[mplier_len] = d;
                  mplier_len++;
               end else begin
                  digits_dropped = 1'b1;
               end
               if (req_last) queue_product();
            end else begin
               if (mcand_len < MAX_DIGITS) begin
                  mcand_digits[mcand_len] = d;
                  mcand_len++;
               end else begin
                  digits_dropped = 1'b1;
               end
            end
         end
      end
      mismatch_count <= tally_fail;
      open_digits    <= product_digit_q.size();
      product_count  <= tally_products;
      digits_checked <= tally_digits;
   end

endmodule

@@ bench/decimal_digit_multiplier_core_tb.sv @@
`timescale 1ns / 100ps
// Top of the decimal digit multiplier bench: clock, reset, digit stimulus and the verdict.
// Depends on dmul_pkg, decimal_digit_multiplier_core and decimal_digit_multiplier_checker.
module decimal_digit_multiplier_core_tb;
   import dmul_pkg::*;

   localparam int   CLOCK_HALF   = 6;
   localparam int   RESET_CYCLES = 10;
   localparam int   RANDOM_WORDS = 300;
   localparam int   LONG_HOLD    = 400;
   localparam int   END_CAP      = 20000;
   localparam int   DRAIN_CYCLES = 50;
   localparam int   LIMIT_NS     = 10_000_000;

   localparam logic KIND_FIRST  = 1'b0;
   localparam logic KIND_SECOND = 1'b1;

   // Digit sources for operand strings
   localparam int FILL_RANDOM = -1;
   localparam int FILL_BINARY = -2;

   // Receiver ready patterns
   localparam int READY_ALWAYS  = 0;
   localparam int READY_COIN    = 1;
   localparam int READY_SPARSE  = 2;
   localparam int READY_CADENCE = 3;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   logic      req_kind;
   digit_type req_digit;
   logic      req_last;
   logic      rsp_valid;
   logic      rsp_ready;
   digit_type rsp_digit_res;
   logic      rsp_last_res;
   logic      rsp_overflow;

   int mismatch_count;
   int open_digits;
   int product_count;
   int digits_checked;

   int words_sent = 0;
   int burst_left = 0;
   int hold_asks  = 0;
   int hold_done  = 0;

   decimal_digit_multiplier_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_digit     (req_digit),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_digit_res (rsp_digit_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow)
   );

   decimal_digit_multiplier_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_digit      (req_digit),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_res  (rsp_digit_res),
      .rsp_last_res   (rsp_last_res),
      .rsp_overflow   (rsp_overflow),
      .mismatch_count (mismatch_count),
      .open_digits    (open_digits),
      .product_count  (product_count),
      .digits_checked (digits_checked)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Give up after a generous fixed time
   initial begin : watchdog
      #LIMIT_NS;
      $display("run timed out with %0d product digits outstanding", open_digits);
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: stall on shifting patterns, with one long hold-off on request
   initial begin : receiver
      int mode;
      int mode_left;
      int phase;
      mode      = READY_ALWAYS;
      mode_left = 0;
      phase     = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done++;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(READY_ALWAYS, READY_CADENCE);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= (phase % 3 != 0);
            endcase
         end
      end
   end

   function automatic digit_type pick_digit(input int fill);
      if (fill >= 0) return 4'(fill);
      if (fill == FILL_BINARY) return 4'($urandom_range(0, 1));
      // Mostly decimal digits, now and then a raw nibble above nine
      if ($urandom_range(0, 11) == 0) return 4'($urandom_range(10, 15));
      return 4'($urandom_range(0, 9));
   endfunction

   // Operand length: mostly short, sometimes medium, rarely long
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(9, 16);
   endfunction

   // Offer one word; idle between bursts, hold until accepted
   task automatic send_word(input logic kind, input digit_type digit, input logic mark);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_digit <= digit;
      req_last  <= mark;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   // Send an operand string; close marks the final second-operand digit
   task automatic send_digits(input logic kind, input int len, input logic close,
                              input int fill);
      logic mark;
      for (int k = 0; k < len; k++) begin
         if (kind == KIND_SECOND) mark = close && (k == len - 1);
         else mark = ($urandom_range(0, 5) == 0);
         send_word(kind, pick_digit(fill), mark);
      end
   endtask

   task automatic send_random_product();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         send_digits(KIND_FIRST, pick_len(), 1'b0, FILL_RANDOM);
         send_digits(KIND_SECOND, pick_len(), 1'b1, FILL_RANDOM);
      end else if (pick < 87) begin
         // first-operand digits resume after some second-operand digits
         send_digits(KIND_FIRST, pick_len(), 1'b0, FILL_RANDOM);
         send_digits(KIND_SECOND, pick_len(), 1'b0, FILL_RANDOM);
         send_digits(KIND_FIRST, pick_len(), 1'b0, FILL_RANDOM);
         send_digits(KIND_SECOND, pick_len(), 1'b1, FILL_RANDOM);
      end else if (pick < 93) begin
         send_digits(KIND_SECOND, pick_len(), 1'b1, FILL_RANDOM);
      end else begin
         send_digits(KIND_FIRST, pick_len(), 1'b0, FILL_BINARY);
         send_digits(KIND_SECOND, pick_len(), 1'b1, FILL_BINARY);
      end
   endtask

   // Stop offering until every product digit has come back
   task automatic drain_results();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (open_digits != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int prod_idx;
      int target;
      int waited;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_kind  <= KIND_FIRST;
      req_digit <= '0;
      req_last  <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single digits at the top of the range
      send_word(KIND_FIRST, 4'd9, 1'b1);
      send_word(KIND_SECOND, 4'd9, 1'b1);
      // zero times a digit
      send_word(KIND_FIRST, 4'd0, 1'b0);
      send_word(KIND_SECOND, 4'd5, 1'b1);
      // raw nibbles above nine saturate; last mark on the first operand does nothing
      send_word(KIND_FIRST, 4'd15, 1'b1);
      send_word(KIND_SECOND, 4'd12, 1'b1);
      // empty first operand
      send_word(KIND_SECOND, 4'd7, 1'b1);
      // leading zeros in both operands
      send_word(KIND_FIRST, 4'd0, 1'b0);
      send_word(KIND_FIRST, 4'd0, 1'b0);
      send_word(KIND_FIRST, 4'd3, 1'b0);
      send_word(KIND_SECOND, 4'd0, 1'b0);
      send_word(KIND_SECOND, 4'd4, 1'b1);
      // first-operand digit arriving after a second-operand digit
      send_word(KIND_FIRST, 4'd2, 1'b0);
      send_word(KIND_SECOND, 4'd3, 1'b0);
      send_word(KIND_FIRST, 4'd5, 1'b0);
      send_word(KIND_SECOND, 4'd1, 1'b1);
      // one times a number
      send_word(KIND_FIRST, 4'd1, 1'b0);
      send_word(KIND_SECOND, 4'd9, 1'b0);
      send_word(KIND_SECOND, 4'd8, 1'b0);
      send_word(KIND_SECOND, 4'd7, 1'b1);
      // two nines by two nines
      send_word(KIND_FIRST, 4'd9, 1'b0);
      send_word(KIND_FIRST, 4'd9, 1'b0);
      send_word(KIND_SECOND, 4'd9, 1'b0);
      send_word(KIND_SECOND, 4'd9, 1'b1);
      drain_results();

      target   = words_sent + RANDOM_WORDS;
      prod_idx = 0;
      while (words_sent < target) begin
         // long output stall while the sender keeps offering
         if (prod_idx == 2) hold_asks++;
         if (prod_idx == 4) begin
            // widest product: all nines on both sides
            send_digits(KIND_FIRST, MAX_DIGITS_DEF, 1'b0, 9);
            send_digits(KIND_SECOND, MAX_DIGITS_DEF, 1'b1, 9);
         end else if (prod_idx == 9) begin
            // both operands too long
            send_digits(KIND_FIRST, MAX_DIGITS_DEF + 2, 1'b0, FILL_RANDOM);
            send_digits(KIND_SECOND, MAX_DIGITS_DEF + 1, 1'b1, FILL_RANDOM);
         end else if (prod_idx == 14) begin
            // second operand too long: the dropped closing digit still starts the multiply
            send_digits(KIND_FIRST, 3, 1'b0, FILL_RANDOM);
            send_digits(KIND_SECOND, MAX_DIGITS_DEF + 4, 1'b1, FILL_RANDOM);
         end else begin
            send_random_product();
         end
         if (prod_idx % 12 == 11) drain_results();
         prod_idx++;
      end

      // Wait out the remaining product digits, then the pipeline tail
      req_valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (open_digits != 0 && waited < END_CAP) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input words in %0d products, %0d product digits checked,",
               words_sent, product_count, digits_checked);
      $display("including saturated nibbles, empty and overflowed operands and a long stall");
      if (open_digits != 0) $display("%0d product digits never arrived", open_digits);
      if (mismatch_count == 0 && open_digits == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ decimal_digit_multiplier_core.f @@
src/dmul_pkg.sv
src/dmul_operands.sv
src/dmul_product.sv
src/decimal_digit_multiplier_core.sv
src/dmul_checker.sv
bench/decimal_digit_multiplier_checker.sv
bench/decimal_digit_multiplier_core_tb.sv
